[design/sbph_pkg.sv]
`timescale 1ns / 1ps

package sbph_pkg;

  localparam int COLUMNS_DEF  = 16;
  localparam int ROWS_DEF     = 8;
  localparam int BANDS_STORED = 16;

  localparam logic signed [15:0] GRAV_THRESH = 16'sd11468;

  localparam logic [1:0] ORI_LAND_A  = 2'd0;
  localparam logic [1:0] ORI_PORT_UP = 2'd1;
  localparam logic [1:0] ORI_LAND_B  = 2'd2;
  localparam logic [1:0] ORI_PORT_DN = 2'd3;

  typedef struct packed {
    logic [3:0]         band_index;
    logic [7:0]         sample_first;
    logic [7:0]         sample_second;
    logic               decay_tick;
    logic               gravity_valid;
    logic signed [15:0] gravity_x;
    logic signed [15:0] gravity_y;
  } in_item_t;

  typedef struct packed {
    logic [3:0] band_out;
    logic       accepted;
    logic [1:0] orientation;
    logic [3:0] bar_height;
    logic [3:0] peak_height;
  } result_t;

endpackage

[design/sbph_in_if.sv]
`timescale 1ns / 1ps

interface sbph_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         band_index;
  logic [7:0]         sample_first;
  logic [7:0]         sample_second;
  logic               decay_tick;
  logic               gravity_valid;
  logic signed [15:0] gravity_x;
  logic signed [15:0] gravity_y;

  modport source (
    output valid, band_index, sample_first, sample_second, decay_tick,
           gravity_valid, gravity_x, gravity_y,
    input  ready
  );

  modport sink (
    input  valid, band_index, sample_first, sample_second, decay_tick,
           gravity_valid, gravity_x, gravity_y,
    output ready
  );
endinterface

[design/sbph_out_if.sv]
`timescale 1ns / 1ps

interface sbph_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] band_out;
  logic       accepted;
  logic [1:0] orientation;
  logic [3:0] bar_height;
  logic [3:0] peak_height;

  modport source (
    output valid, band_out, accepted, orientation, bar_height, peak_height,
    input  ready
  );

  modport sink (
    input  valid, band_out, accepted, orientation, bar_height, peak_height,
    output ready
  );
endinterface

[design/spectrum_bar_peak_hold.sv]
`timescale 1ns / 1ps
// channel  | modport | payload
// ---------+---------+-----------------------------------------------------------
// in_ch    | sink    | band_index, sample_first, sample_second, decay_tick,
//          |         | gravity_valid, gravity_x, gravity_y
// out_ch   | source  | band_out, accepted, orientation, bar_height, peak_height
//
// One request per cycle sustained while out_ch.ready holds high; each request
// is registered in the input register, then in the result register.
// Per-band state is read and written between those two registers, so each
// request sees every earlier update.
// Reset clears all band levels and peaks; no clearing pass.
// A stalled result holds in the output register while one more request waits
// in the input register.

module spectrum_bar_peak_hold
  import sbph_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sbph_in_if.sink    in_ch,
  sbph_out_if.source out_ch
);

  in_item_t   item_r;
  in_item_t   item_nxt;
  logic       in_valid_r;
  logic       in_valid_nxt;
  result_t    res_r;
  result_t    res_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       advance;
  logic       in_fire;
  logic [1:0] orientation;

  assign advance = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    item_nxt.band_index    = in_ch.band_index;
    item_nxt.sample_first  = in_ch.sample_first;
    item_nxt.sample_second = in_ch.sample_second;
    item_nxt.decay_tick    = in_ch.decay_tick;
    item_nxt.gravity_valid = in_ch.gravity_valid;
    item_nxt.gravity_x     = in_ch.gravity_x;
    item_nxt.gravity_y     = in_ch.gravity_y;
    in_valid_nxt  = in_fire || (in_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_ch.ready);
  end

  sbph_orient u_orient (
    .gravity_valid (item_r.gravity_valid),
    .gravity_x     (item_r.gravity_x),
    .gravity_y     (item_r.gravity_y),
    .orientation   (orientation)
  );

  sbph_band_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_band (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .item        (item_r),
    .orientation (orientation),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.band_out    = res_r.band_out;
  assign out_ch.accepted    = res_r.accepted;
  assign out_ch.orientation = res_r.orientation;
  assign out_ch.bar_height  = res_r.bar_height;
  assign out_ch.peak_height = res_r.peak_height;

`ifndef ASSERT_OFF
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.accepted) |->
      (out_ch.bar_height == 4'd0 && out_ch.peak_height == 4'd0))
    else $error("rejected band carries nonzero heights");

  a_portrait_bands: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.accepted && out_ch.orientation[0]) |->
      (32'(out_ch.band_out) < ROWS))
    else $error("portrait band beyond band count accepted");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled while a stage is free");

  a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_ch.valid)
    else $error("advanced request produced no result");
`endif

endmodule

[design/sbph_orient.sv]
`timescale 1ns / 1ps

module sbph_orient
  import sbph_pkg::*;
(
  input  logic               gravity_valid,
  input  logic signed [15:0] gravity_x,
  input  logic signed [15:0] gravity_y,
  output logic [1:0]         orientation
);

  always_comb begin
    priority if (gravity_valid && (gravity_y > GRAV_THRESH)) begin
      orientation = ORI_PORT_UP;
    end else if (gravity_valid && (gravity_y < -GRAV_THRESH)) begin
      orientation = ORI_PORT_DN;
    end else if (gravity_valid && (gravity_x > GRAV_THRESH)) begin
      orientation = ORI_LAND_B;
    end else begin
      orientation = ORI_LAND_A;
    end
  end

endmodule

[design/sbph_band_unit.sv]
`timescale 1ns / 1ps

module sbph_band_unit
  import sbph_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  in_item_t   item,
  input  logic [1:0] orientation,
  output result_t    res
);

  // portrait: ROWS bands over COLUMNS levels; landscape the other way round
  localparam int P_TOP = COLUMNS - 1;
  localparam int L_TOP = ROWS - 1;
  localparam int P_DIV = (255 / P_TOP < 1) ? 1 : 255 / P_TOP;
  localparam int L_DIV = (255 / L_TOP < 1) ? 1 : 255 / L_TOP;
  localparam logic [16:0] P_RECIP = 17'((65536 + P_DIV - 1) / P_DIV);
  localparam logic [16:0] L_RECIP = 17'((65536 + L_DIV - 1) / L_DIV);
  localparam logic [3:0]  P_CAP   = 4'((P_TOP > 15) ? 15 : P_TOP);
  localparam logic [3:0]  L_CAP   = 4'((L_TOP > 15) ? 15 : L_TOP);
  localparam logic [6:0]  P_BANDS = 7'(ROWS);
  localparam logic [6:0]  L_BANDS = 7'(COLUMNS);

  logic [7:0] smooth_r [BANDS_STORED];
  logic [3:0] peak_r   [BANDS_STORED];

  logic       portrait;
  logic       ok;
  logic [8:0] pair_sum;
  logic [7:0] raw;
  logic [7:0] smooth_cur;
  logic [3:0] peak_cur;
  logic [9:0] acc;
  logic [7:0] avg;
  logic [24:0] prod_p;
  logic [24:0] prod_l;
  logic [8:0] quot;
  logic [3:0] bar;
  logic [3:0] cap;
  logic [3:0] peak_up;
  logic [3:0] peak_nxt;

  always_comb begin
    portrait   = orientation[0];
    ok         = {3'b000, item.band_index} < (portrait ? P_BANDS : L_BANDS);
    pair_sum   = 9'(item.sample_first) + 9'(item.sample_second);
    raw        = portrait ? pair_sum[8:1] : item.sample_first;
    smooth_cur = smooth_r[item.band_index];
    peak_cur   = peak_r[item.band_index];
    acc        = 10'({smooth_cur, 1'b0}) + 10'(smooth_cur) + 10'(raw);
    avg        = acc[9:2];
    // exact for 8-bit dividends: reciprocal error stays below 2^8
    prod_p     = 25'(avg) * 25'(P_RECIP);
    prod_l     = 25'(avg) * 25'(L_RECIP);
    quot       = portrait ? prod_p[24:16] : prod_l[24:16];
    bar        = (quot > 9'd15) ? 4'd15 : quot[3:0];
    cap        = portrait ? P_CAP : L_CAP;
    peak_up    = (bar > peak_cur) ? ((bar < cap) ? bar : cap) : peak_cur;
    peak_nxt   = (item.decay_tick && (peak_up != 4'd0)) ? peak_up - 4'd1 : peak_up;

    res.band_out    = item.band_index;
    res.accepted    = ok;
    res.orientation = orientation;
    res.bar_height  = ok ? bar : 4'd0;
    res.peak_height = ok ? peak_nxt : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BANDS_STORED; i++) begin
        smooth_r[i] <= 8'd0;
        peak_r[i]   <= 4'd0;
      end
    end else if (en && ok) begin
      smooth_r[item.band_index] <= avg;
      peak_r[item.band_index]   <= peak_nxt;
    end
  end

endmodule
